// ----- hdl/can_id_traffic_monitor_table_macros.svh -----
// ----------------------------------------------------------------------------
// can_id_traffic_monitor_table_macros
// assertion macros used by the traffic monitor table rtl
// ----------------------------------------------------------------------------
`ifndef CAN_ID_TRAFFIC_MONITOR_TABLE_MACROS_SVH
`define CAN_ID_TRAFFIC_MONITOR_TABLE_MACROS_SVH

`ifndef SYNTH
// checked property, switched off while reset is applied
`define CTM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctm assertion failed");
// checked property, held during reset as well
`define CTM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ctm assertion failed");
`else
`define CTM_ASSERT(name, clk, rst_n, prop)
`define CTM_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- hdl/ctm_pkg.sv -----
// ----------------------------------------------------------------------------
// ctm_pkg
// types and constants of the can identifier traffic monitor table
// ----------------------------------------------------------------------------
`default_nettype none

package ctm_pkg;

  // one observed frame
  typedef struct packed {
    logic [7:0]  frame_kind;
    logic [28:0] frame_id;
    logic [31:0] stamp;
    logic [3:0]  data_len;
  } frame_t;

  // one result transaction
  typedef struct packed {
    logic [5:0]  row_index;
    logic        is_new;
    logic        table_full;
    logic [31:0] hit_total;
    logic        period_valid;
    logic [31:0] shown_period;
    logic [3:0]  length_out;
  } result_t;

  // contents of one table entry
  typedef struct packed {
    logic [28:0] slot_id;
    logic [7:0]  slot_kind;
    logic [31:0] slot_stamp;
    logic [31:0] slot_last_period;
    logic [31:0] slot_prior_period;
    logic [31:0] slot_hits;
  } entry_t;

  // write-back of the statistics of the selected entry
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] last_period;
    logic [31:0] prior_period;
    logic [31:0] hits;
  } wb_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic compare;
    logic insert;
    logic pick;
    logic found;
    logic update;
    wb_t  wb;
  } ctl_t;

  // mean of three periods rounded to five: divide the sum by fifteen
  localparam int unsigned DIV_DIGITS   = 9;
  localparam int unsigned DIV_W        = 4 * DIV_DIGITS;
  localparam int unsigned DIVISOR      = 15;
  localparam int unsigned ROUND_UP_REM = 6;
  localparam int unsigned ROUND_STEP   = 5;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- hdl/ctm_cell.sv -----
// ----------------------------------------------------------------------------
// ctm_cell
// one table entry: key compare, shift from the left neighbour, update
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_cell (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  ctm_pkg::ctl_t   ctl_i,
  input  wire  ctm_pkg::frame_t key_i,
  input  wire  logic            left_valid_i,
  input  wire  ctm_pkg::entry_t left_entry_i,
  input  wire  logic            left_pos_i,
  output logic                  valid_o,
  output ctm_pkg::entry_t       entry_o,
  output logic                  match_o,
  output logic                  pos_o
);

  logic            valid_q;
  logic            match_q;
  logic            pos_q;
  logic            sel_q;
  ctm_pkg::entry_t entry_q;
  logic            key_before;
  logic            key_equal;
  logic            boundary;

  assign key_equal  = (key_i.frame_id == entry_q.slot_id) &&
                      (key_i.frame_kind == entry_q.slot_kind);
  assign key_before = (key_i.frame_id < entry_q.slot_id) ||
                      ((key_i.frame_id == entry_q.slot_id) &&
                       (key_i.frame_kind < entry_q.slot_kind));
  // first cell at or after the insertion point
  assign boundary   = pos_q & ~left_pos_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      pos_q   <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (ctl_i.compare) begin
        match_q <= valid_q & key_equal;
        pos_q   <= ~valid_q | key_before;
      end
      if (ctl_i.insert && pos_q) begin
        valid_q <= left_pos_i ? left_valid_i : 1'b1;
      end
      if (ctl_i.pick) begin
        sel_q <= ctl_i.found ? match_q : boundary;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.insert && pos_q) begin
      if (left_pos_i) begin
        entry_q <= left_entry_i;
      end else begin
        entry_q.slot_id           <= key_i.frame_id;
        entry_q.slot_kind         <= key_i.frame_kind;
        entry_q.slot_stamp        <= key_i.stamp;
        entry_q.slot_last_period  <= '0;
        entry_q.slot_prior_period <= '0;
        entry_q.slot_hits         <= '0;
      end
    end else if (ctl_i.update && sel_q) begin
      entry_q.slot_stamp        <= ctl_i.wb.stamp;
      entry_q.slot_last_period  <= ctl_i.wb.last_period;
      entry_q.slot_prior_period <= ctl_i.wb.prior_period;
      entry_q.slot_hits         <= ctl_i.wb.hits;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign match_o = match_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

// ----- hdl/ctm_div15.sv -----
// ----------------------------------------------------------------------------
// ctm_div15
// divide by fifteen: shifted partial sums, then a small remainder fix-up
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_div15 (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  logic                      start_i,
  input  wire  logic [ctm_pkg::DIV_W-1:0] num_i,
  output logic                            done_o,
  output logic [ctm_pkg::DIV_W-1:0]       quo_o,
  output logic [3:0]                      rem_o
);

  // x / 15 is close to the sum of x shifted down by every multiple of four bits
  localparam int unsigned GROUP_TERMS = 3;
  localparam int unsigned GROUPS      = ctm_pkg::DIV_DIGITS / GROUP_TERMS;

  logic [2:0]                stage_q;
  logic                      done_q;
  logic [ctm_pkg::DIV_W-1:0] num_q;
  logic [ctm_pkg::DIV_W-1:0] grp_q [GROUPS];
  logic [ctm_pkg::DIV_W-1:0] grp_d [GROUPS];
  logic [ctm_pkg::DIV_W-1:0] est_q;
  logic [ctm_pkg::DIV_W-1:0] est_d;
  logic [7:0]                rem_raw;
  logic [7:0]                rem_fix;
  logic [3:0]                fix_d;
  logic [ctm_pkg::DIV_W-1:0] quo_q;
  logic [3:0]                rem_q;

  // partial sums of the shifted dividend
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP_TERMS; j++) begin
        grp_d[g] = grp_d[g] + (num_q >> (4 * (g * GROUP_TERMS + j + 1)));
      end
    end
  end

  always_comb begin
    est_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      est_d = est_d + grp_q[g];
    end
  end

  // the estimate is short by at most nine, so num - 15 * est fits in a byte
  always_comb begin
    rem_raw = num_q[7:0] - {est_q[3:0], 4'b0000} + est_q[7:0];
    rem_fix = rem_raw;
    fix_d   = '0;
    for (int b = 3; b >= 0; b--) begin
      if (rem_fix >= 8'(ctm_pkg::DIVISOR << b)) begin
        rem_fix  = rem_fix - 8'(ctm_pkg::DIVISOR << b);
        fix_d[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
      done_q  <= stage_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
    end
    if (stage_q[0]) begin
      grp_q <= grp_d;
    end
    if (stage_q[1]) begin
      est_q <= est_d;
    end
    if (stage_q[2]) begin
      quo_q <= est_q + ctm_pkg::DIV_W'(fix_d);
      rem_q <= rem_fix[3:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- hdl/can_id_traffic_monitor_table.sv -----
// ----------------------------------------------------------------------------
// can_id_traffic_monitor_table
// per-identifier frame counter and period monitor for observed can frames
// ----------------------------------------------------------------------------
// A frame is taken when start is high and busy is low. The table is a row of
// TABLE_ENTRIES cells kept sorted by identifier and then frame type; every
// cell compares the key at once, and a new key is inserted by shifting every
// cell above the insertion point one step up the row together. Each frame
// gives exactly one result on result_o, shown for one cycle with done_o
// high; the receiver cannot stall, so it must take the transaction in that
// cycle. A frame that matches or inserts keeps busy high through the
// compare, the select/insert and the update, and then while the divide by
// fifteen forms the rounded mean; the divide is the longest part. A new
// identifier that finds the table full is dropped after the compare and
// select steps with table_full set. done_o rises in the same cycle that
// busy falls, and a new frame may already be taken in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_id_traffic_monitor_table_macros.svh"

module can_id_traffic_monitor_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             start,
  output logic                   busy,
  input  wire  ctm_pkg::frame_t  frame_i,
  output logic                   done_o,
  output ctm_pkg::result_t       result_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;

  logic [2:0]       state_q;
  logic [2:0]       state_d;
  ctm_pkg::frame_t  frame_q;
  ctm_pkg::ctl_t    ctl;

  // row of cells
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] pos_vec;
  ctm_pkg::entry_t          entry_arr [TABLE_ENTRIES];

  // selection
  logic                     found;
  logic                     full;
  logic [TABLE_ENTRIES-1:0] boundary_vec;
  logic [TABLE_ENTRIES-1:0] row_vec;
  logic [IDX_W-1:0]         row_d;
  logic [31:0]              pick_stamp;
  logic [31:0]              pick_last;
  logic [31:0]              pick_prior;
  logic [31:0]              pick_hits;

  // selected entry and running result fields
  logic [IDX_W-1:0] row_q;
  logic             fresh_q;
  logic [31:0]      s_stamp_q;
  logic [31:0]      s_last_q;
  logic [31:0]      s_prior_q;
  logic [31:0]      s_hits_q;
  logic             pvalid_q;
  logic [31:0]      hits_new_q;

  // period update
  logic                            stamp_ok;
  logic [31:0]                     new_period;
  logic [33:0]                     period_sum;
  logic [31:0]                     hits_inc;
  logic [ctm_pkg::DIV_W-1:0]       div_num;
  logic                            div_done;
  logic [ctm_pkg::DIV_W-1:0]       div_quo;
  logic [3:0]                      div_rem;
  logic [ctm_pkg::DIV_W+1:0]       mean_wide;
  logic [31:0]                     mean_sat;
  logic [IDX_W+5:0]                row_ext;

  // output register
  ctm_pkg::result_t res_q;
  ctm_pkg::result_t res_d;
  logic             done_q;
  logic             done_d;

  // --------------------------------------------------------------------------
  // cell row, each cell fed by its left neighbour
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic            left_valid;
    logic            left_pos;
    ctm_pkg::entry_t left_entry;

    if (g == 0) begin : g_first
      assign left_valid = 1'b0;
      assign left_pos   = 1'b0;
      assign left_entry = '0;
    end else begin : g_rest
      assign left_valid = valid_vec[g-1];
      assign left_pos   = pos_vec[g-1];
      assign left_entry = entry_arr[g-1];
    end

    ctm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (frame_q),
      .left_valid_i (left_valid),
      .left_entry_i (left_entry),
      .left_pos_i   (left_pos),
      .valid_o      (valid_vec[g]),
      .entry_o      (entry_arr[g]),
      .match_o      (match_vec[g]),
      .pos_o        (pos_vec[g])
    );
  end

  // --------------------------------------------------------------------------
  // select: at most one cell matches; otherwise the insertion point is the
  // first cell that is empty or holds a larger key
  // --------------------------------------------------------------------------
  assign found        = |match_vec;
  assign full         = ~found & valid_vec[TABLE_ENTRIES-1];
  assign boundary_vec = pos_vec & ~{pos_vec[TABLE_ENTRIES-2:0], 1'b0};
  assign row_vec      = found ? match_vec : boundary_vec;

  always_comb begin
    row_d      = '0;
    pick_stamp = '0;
    pick_last  = '0;
    pick_prior = '0;
    pick_hits  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (row_vec[i]) begin
        row_d = row_d | IDX_W'(i);
      end
      if (match_vec[i]) begin
        pick_stamp = pick_stamp | entry_arr[i].slot_stamp;
        pick_last  = pick_last  | entry_arr[i].slot_last_period;
        pick_prior = pick_prior | entry_arr[i].slot_prior_period;
        pick_hits  = pick_hits  | entry_arr[i].slot_hits;
      end
    end
  end

  // --------------------------------------------------------------------------
  // period and count update; a fresh entry carries the frame's own stamp
  // --------------------------------------------------------------------------
  assign stamp_ok   = (s_stamp_q <= frame_q.stamp);
  assign new_period = stamp_ok ? (frame_q.stamp - s_stamp_q) : s_last_q;
  assign period_sum = {2'b00, new_period} + {2'b00, s_last_q} + {2'b00, s_prior_q};
  assign hits_inc   = (s_hits_q == ctm_pkg::COUNT_MAX) ? s_hits_q : (s_hits_q + 32'd1);
  assign div_num    = ctm_pkg::DIV_W'(period_sum);

  ctm_div15 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_CALC),
    .num_i   (div_num),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // mean = sum / 3 = 5q + r/3 with q, r from sum / 15; round on r/3 >= 2
  assign mean_wide = {div_quo, 2'b00} + {2'b00, div_quo} +
                     ((div_rem >= 4'(ctm_pkg::ROUND_UP_REM)) ?
                      (ctm_pkg::DIV_W+2)'(ctm_pkg::ROUND_STEP) : '0);
  assign mean_sat  = (|mean_wide[ctm_pkg::DIV_W+1:32]) ? ctm_pkg::COUNT_MAX
                                                       : mean_wide[31:0];
  assign row_ext   = {6'b000000, row_q};

  // --------------------------------------------------------------------------
  // broadcast control
  // --------------------------------------------------------------------------
  always_comb begin
    ctl                 = '0;
    ctl.compare         = (state_q == ST_CMP);
    ctl.insert          = (state_q == ST_SEL) && !found && !full;
    ctl.pick            = (state_q == ST_SEL);
    ctl.found           = found;
    ctl.update          = (state_q == ST_CALC);
    ctl.wb.stamp        = frame_q.stamp;
    ctl.wb.last_period  = new_period;
    ctl.wb.prior_period = s_last_q;
    ctl.wb.hits         = hits_inc;
  end

  // --------------------------------------------------------------------------
  // sequencer and result
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_SEL;
      end
      ST_SEL: begin
        if (full) begin
          // dropped frame, state untouched
          state_d            = ST_IDLE;
          done_d             = 1'b1;
          res_d              = '0;
          res_d.table_full   = 1'b1;
          res_d.length_out   = frame_q.data_len;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d            = ST_IDLE;
          done_d             = 1'b1;
          res_d.row_index    = row_ext[5:0];
          res_d.is_new       = fresh_q;
          res_d.table_full   = 1'b0;
          res_d.hit_total    = hits_new_q;
          res_d.period_valid = pvalid_q;
          res_d.shown_period = pvalid_q ? mean_sat : '0;
          res_d.length_out   = frame_q.data_len;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      frame_q <= frame_i;
    end
    if (state_q == ST_SEL) begin
      row_q   <= row_d;
      fresh_q <= ~found;
      if (found) begin
        s_stamp_q <= pick_stamp;
        s_last_q  <= pick_last;
        s_prior_q <= pick_prior;
        s_hits_q  <= pick_hits;
      end else begin
        s_stamp_q <= frame_q.stamp;
        s_last_q  <= '0;
        s_prior_q <= '0;
        s_hits_q  <= '0;
      end
    end
    if (state_q == ST_CALC) begin
      pvalid_q   <= stamp_ok;
      hits_new_q <= hits_inc;
    end
    res_q <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CTM_ASSERT(a_match_unique, clk_i, rst_ni, (state_q == ST_SEL) |-> $onehot0(match_vec))
  `CTM_ASSERT_ALWAYS(a_valid_prefix, clk_i, ((valid_vec >> 1) & ~valid_vec) == '0)
  `CTM_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `CTM_ASSERT(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy))
  `CTM_ASSERT(a_drop_clean, clk_i, rst_ni,
              (done_o && result_o.table_full) |-> (result_o.hit_total == '0 && !result_o.is_new))

endmodule

`default_nettype wire
